>>> src/csvt_pkg.sv
// Shared types, character codes and defaults for the CSV stream tokenizer.
package csvt_pkg;

    localparam int MAX_PENDING_SPACE_DEF = 32;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [7:0] DELIM_RESET = 8'd44;

    typedef enum logic [1:0] {
        TK_BYTE   = 2'd0,
        TK_FIELD  = 2'd1,
        TK_RECORD = 2'd2,
        TK_ERROR  = 2'd3
    } t_token_kind;

    typedef enum logic [2:0] {
        ERR_AFTER_QUOTE = 3'd0,
        ERR_MISPLACED   = 3'd1,
        ERR_OPEN_QUOTE  = 3'd2,
        ERR_BAD_DELIM   = 3'd3,
        ERR_WS_OVERFLOW = 3'd4
    } t_err_code;

    typedef enum logic [1:0] {
        QM_OUTSIDE = 2'd0,
        QM_INSIDE  = 2'd1,
        QM_QSEEN   = 2'd2,
        QM_CLOSED  = 2'd3
    } t_quote_mode;

    typedef enum logic [1:0] {
        REG_DELIM      = 2'd0,
        REG_TRIM       = 2'd1,
        REG_SKIP_BLANK = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        ST_IDLE       = 2'd0,
        ST_FLUSH_RD   = 2'd1,
        ST_FLUSH_EMIT = 2'd2,
        ST_FLUSH_HOLD = 2'd3
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_space;
        logic emit_space;
        logic emit_hold;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic flush_req;
        logic last_space;
    } t_dp_status;

endpackage

>>> src/csv_stream_tokenizer_top.sv
// CSV stream tokenizer: one text byte per input word, field/record/error tokens out.
// Most input bytes give at most one token, held in an output register; the next
// byte is taken in the cycle that token is taken or once the register is empty,
// so a stalled token holds off the input. A content byte that follows N stored
// trailing blanks (trimming on) keeps the input stalled while each stored blank is
// read from the pending-space memory and sent on; then the held byte follows.
// After the first error the block swallows all input until reset; an invalid
// separator setting is reported as an error on the next word and latches the
// same way.
module csv_stream_tokenizer_top #(
    parameter int MAX_PENDING_SPACE = csvt_pkg::MAX_PENDING_SPACE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_token_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_was_quoted,
    output logic [2:0]  o_error_code,
    output logic [31:0] o_line_number,
    output logic [15:0] o_column_number,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    csvt_pkg::t_ctrl_cmd  cmd;
    csvt_pkg::t_dp_status status;

    csvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    csvt_dp #(
        .MAX_PENDING_SPACE (MAX_PENDING_SPACE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_token_kind    (o_token_kind),
        .o_out_byte      (o_out_byte),
        .o_was_quoted    (o_was_quoted),
        .o_error_code    (o_error_code),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

>>> src/csvt_ctrl.sv
// Controller state machine: byte acceptance and the trailing-space flush sequence.
module csvt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  csvt_pkg::t_dp_status  i_status,
    output csvt_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_in_stall
);

    csvt_pkg::t_state r_state;
    csvt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csvt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_in_stall       = 1'b1;
        unique case (r_state)
            csvt_pkg::ST_IDLE: begin
                o_in_stall = !i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.flush_req) begin
                        n_state = csvt_pkg::ST_FLUSH_RD;
                    end
                end
            end
            csvt_pkg::ST_FLUSH_RD: begin
                o_cmd.rd_space = 1'b1;
                n_state        = csvt_pkg::ST_FLUSH_EMIT;
            end
            csvt_pkg::ST_FLUSH_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_space = 1'b1;
                    n_state = i_status.last_space ? csvt_pkg::ST_FLUSH_HOLD
                                                  : csvt_pkg::ST_FLUSH_RD;
                end
            end
            csvt_pkg::ST_FLUSH_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_hold = 1'b1;
                    n_state         = csvt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = csvt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/csvt_dp.sv
// Datapath: configuration, parse state, pending-space store and output register.
module csvt_dp #(
    parameter int MAX_PENDING_SPACE = csvt_pkg::MAX_PENDING_SPACE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  csvt_pkg::t_ctrl_cmd   i_cmd,
    output csvt_pkg::t_dp_status  o_status,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_end_of_stream,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [1:0]            o_token_kind,
    output logic [7:0]            o_out_byte,
    output logic                  o_was_quoted,
    output logic [2:0]            o_error_code,
    output logic [31:0]           o_line_number,
    output logic [15:0]           o_column_number,
    output logic                  o_last_of_run
);

    localparam int CW = $clog2(MAX_PENDING_SPACE + 1);
    localparam int IW = (MAX_PENDING_SPACE > 1) ? $clog2(MAX_PENDING_SPACE) : 1;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PENDING_SPACE);

    // Configuration.
    logic [7:0] r_delim;
    logic       r_trim;
    logic       r_skip_blank;

    // Parse state.
    csvt_pkg::t_quote_mode r_qm, n_qm;
    logic          r_cr, n_cr;
    logic          r_fq, n_fq;
    logic          r_ne, n_ne;
    logic          r_rec, n_rec;
    logic [15:0]   r_fields, n_fields;
    logic [31:0]   r_line, n_line;
    logic [CW-1:0] r_count, n_count;
    logic          r_errl, n_errl;

    // Flush support.
    logic          r_space_mem [MAX_PENDING_SPACE];
    logic [IW-1:0] r_idx;
    logic          r_rd_kind;
    logic [7:0]    r_hold;

    // Output register.
    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_byte;
    logic          r_q;
    logic [2:0]    r_ecode;
    logic [31:0]   r_eline;
    logic [15:0]   r_ecol;
    logic          r_last;

    // Result of an accepted word.
    logic          res_v;
    logic [1:0]    res_kind;
    logic [7:0]    res_byte;
    logic          res_q;
    logic [2:0]    res_ecode;
    logic          res_err;
    logic          push;
    logic          flush;

    logic          out_free;
    logic          bad_delim;
    logic [CW-1:0] idx_next;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign bad_delim = (r_delim == csvt_pkg::CH_NUL) || (r_delim == csvt_pkg::CH_QUOTE) ||
                       (r_delim == csvt_pkg::CH_CR)  || (r_delim == csvt_pkg::CH_LF);
    assign idx_next  = CW'(r_idx) + CW'(1);

    always_comb begin
        logic f_ef;
        logic f_er;
        logic f_nl;
        logic f_cs;
        logic blank;
        csvt_pkg::t_quote_mode qm_eff;

        n_qm      = r_qm;
        n_cr      = r_cr;
        n_fq      = r_fq;
        n_ne      = r_ne;
        n_rec     = r_rec;
        n_fields  = r_fields;
        n_line    = r_line;
        n_count   = r_count;
        n_errl    = r_errl;
        res_v     = 1'b0;
        res_kind  = csvt_pkg::TK_BYTE;
        res_byte  = 8'd0;
        res_q     = 1'b0;
        res_ecode = 3'd0;
        res_err   = 1'b0;
        push      = 1'b0;
        flush     = 1'b0;
        f_ef      = 1'b0;
        f_er      = 1'b0;
        f_nl      = 1'b0;
        f_cs      = 1'b0;
        blank     = 1'b0;
        qm_eff    = r_qm;

        if (i_cmd.accept && !r_errl) begin
            if (bad_delim) begin
                // A bad separator is reported on the word that meets it.
                res_err   = 1'b1;
                res_ecode = csvt_pkg::ERR_BAD_DELIM;
            end else if (i_end_of_stream) begin
                n_cr = 1'b0;
                if (r_qm == csvt_pkg::QM_INSIDE) begin
                    res_err   = 1'b1;
                    res_ecode = csvt_pkg::ERR_OPEN_QUOTE;
                end else begin
                    f_er = r_rec || (r_qm != csvt_pkg::QM_OUTSIDE) || (r_fields != 16'd0) ||
                           r_ne;
                    f_cs = 1'b1;
                end
            end else if (!(r_cr && i_in_byte == csvt_pkg::CH_LF)) begin
                n_cr = 1'b0;
                if (r_qm == csvt_pkg::QM_QSEEN && i_in_byte == csvt_pkg::CH_QUOTE) begin
                    // Doubled quote inside a quoted field.
                    res_v    = 1'b1;
                    res_byte = csvt_pkg::CH_QUOTE;
                    n_qm     = csvt_pkg::QM_INSIDE;
                end else begin
                    if (r_qm == csvt_pkg::QM_QSEEN) begin
                        qm_eff = csvt_pkg::QM_CLOSED;
                        n_qm   = csvt_pkg::QM_CLOSED;
                    end
                    if (qm_eff == csvt_pkg::QM_INSIDE) begin
                        if (i_in_byte == csvt_pkg::CH_QUOTE) begin
                            n_qm = csvt_pkg::QM_QSEEN;
                        end else if (i_in_byte == csvt_pkg::CH_CR ||
                                     i_in_byte == csvt_pkg::CH_LF) begin
                            res_v    = 1'b1;
                            res_byte = csvt_pkg::CH_LF;
                            f_nl     = 1'b1;
                        end else begin
                            res_v    = 1'b1;
                            res_byte = i_in_byte;
                        end
                    end else if (qm_eff == csvt_pkg::QM_CLOSED) begin
                        if (i_in_byte == r_delim) begin
                            f_ef = 1'b1;
                        end else if (i_in_byte == csvt_pkg::CH_SP ||
                                     i_in_byte == csvt_pkg::CH_TAB) begin
                            n_qm = csvt_pkg::QM_CLOSED;
                        end else if (i_in_byte == csvt_pkg::CH_CR ||
                                     i_in_byte == csvt_pkg::CH_LF) begin
                            f_er = 1'b1;
                            f_nl = 1'b1;
                        end else begin
                            res_err   = 1'b1;
                            res_ecode = csvt_pkg::ERR_AFTER_QUOTE;
                        end
                    end else begin
                        if (i_in_byte == r_delim) begin
                            f_ef = 1'b1;
                        end else if (i_in_byte == csvt_pkg::CH_CR ||
                                     i_in_byte == csvt_pkg::CH_LF) begin
                            f_er = 1'b1;
                            f_nl = 1'b1;
                        end else if (i_in_byte == csvt_pkg::CH_QUOTE) begin
                            if (r_ne) begin
                                res_err   = 1'b1;
                                res_ecode = csvt_pkg::ERR_MISPLACED;
                            end else begin
                                n_count = '0;
                                n_fq    = 1'b1;
                                n_qm    = csvt_pkg::QM_INSIDE;
                                n_rec   = 1'b1;
                            end
                        end else begin
                            n_rec = 1'b1;
                            if (r_trim && (i_in_byte == csvt_pkg::CH_SP ||
                                           i_in_byte == csvt_pkg::CH_TAB)) begin
                                if (r_ne) begin
                                    if (r_count >= COUNT_MAX) begin
                                        res_err   = 1'b1;
                                        res_ecode = csvt_pkg::ERR_WS_OVERFLOW;
                                        n_rec     = r_rec;
                                    end else begin
                                        push    = 1'b1;
                                        n_count = r_count + CW'(1);
                                    end
                                end
                            end else begin
                                n_ne = 1'b1;
                                if (r_count != '0) begin
                                    // Stored blanks go out first; the byte waits.
                                    flush = 1'b1;
                                end else begin
                                    res_v    = 1'b1;
                                    res_byte = i_in_byte;
                                end
                            end
                        end
                    end
                end
            end else begin
                // LF completing a CRLF is consumed.
                n_cr = 1'b0;
            end

            if (f_ef) begin
                res_v    = 1'b1;
                res_kind = csvt_pkg::TK_FIELD;
                res_q    = r_fq;
                n_fields = (r_fields < 16'hFFFF) ? r_fields + 16'd1 : r_fields;
                n_fq     = 1'b0;
                n_ne     = 1'b0;
                n_count  = '0;
                n_qm     = csvt_pkg::QM_OUTSIDE;
                n_rec    = 1'b1;
            end
            if (f_er) begin
                blank    = (r_fields == 16'd0) && !r_fq && !r_ne;
                res_v    = !(r_skip_blank && blank);
                res_kind = csvt_pkg::TK_RECORD;
                res_q    = r_fq;
                n_fields = 16'd0;
                n_rec    = 1'b0;
                n_fq     = 1'b0;
                n_ne     = 1'b0;
                n_count  = '0;
                n_qm     = csvt_pkg::QM_OUTSIDE;
            end
            if (f_nl) begin
                n_line = (r_line != 32'hFFFF_FFFF) ? r_line + 32'd1 : r_line;
                n_cr   = (i_in_byte == csvt_pkg::CH_CR);
            end
            if (f_cs) begin
                n_fq     = 1'b0;
                n_ne     = 1'b0;
                n_count  = '0;
                n_qm     = csvt_pkg::QM_OUTSIDE;
                n_cr     = 1'b0;
                n_rec    = 1'b0;
                n_fields = 16'd0;
                n_line   = 32'd1;
            end
            if (res_err) begin
                res_v    = 1'b1;
                res_kind = csvt_pkg::TK_ERROR;
                n_errl   = 1'b1;
            end
        end

        if (i_cmd.emit_hold) begin
            n_count = '0;
        end
    end

    assign o_status.out_free   = out_free;
    assign o_status.flush_req  = flush;
    assign o_status.last_space = (idx_next == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim      <= csvt_pkg::DELIM_RESET;
            r_trim       <= 1'b1;
            r_skip_blank <= 1'b1;
            r_qm         <= csvt_pkg::QM_OUTSIDE;
            r_cr         <= 1'b0;
            r_fq         <= 1'b0;
            r_ne         <= 1'b0;
            r_rec        <= 1'b0;
            r_fields     <= 16'd0;
            r_line       <= 32'd1;
            r_count      <= '0;
            r_errl       <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (csvt_pkg::t_reg_index'(i_cfg_index))
                    csvt_pkg::REG_DELIM:      r_delim      <= i_cfg_data;
                    csvt_pkg::REG_TRIM:       r_trim       <= i_cfg_data[0];
                    csvt_pkg::REG_SKIP_BLANK: r_skip_blank <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_qm     <= n_qm;
            r_cr     <= n_cr;
            r_fq     <= n_fq;
            r_ne     <= n_ne;
            r_rec    <= n_rec;
            r_fields <= n_fields;
            r_line   <= n_line;
            r_count  <= n_count;
            r_errl   <= n_errl;
            if (i_cmd.emit_space) begin
                r_idx <= r_idx + IW'(1);
            end else if (i_cmd.emit_hold) begin
                r_idx <= '0;
            end
            if (res_v || i_cmd.emit_space || i_cmd.emit_hold) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pending-space store, hold byte and output payload.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_space_mem[r_count[IW-1:0]] <= (i_in_byte == csvt_pkg::CH_TAB);
        end
        if (i_cmd.rd_space) begin
            r_rd_kind <= r_space_mem[r_idx];
        end
        if (flush) begin
            r_hold <= i_in_byte;
        end
        if (res_v) begin
            r_kind  <= res_kind;
            r_byte  <= res_byte;
            r_q     <= res_q;
            r_ecode <= res_err ? res_ecode : 3'd0;
            r_eline <= res_err ? r_line : 32'd0;
            r_ecol  <= res_err ? ((r_fields == 16'hFFFF) ? 16'hFFFF : r_fields + 16'd1)
                               : 16'd0;
            r_last  <= 1'b1;
        end else if (i_cmd.emit_space || i_cmd.emit_hold) begin
            r_kind  <= csvt_pkg::TK_BYTE;
            r_byte  <= i_cmd.emit_hold ? r_hold
                                       : (r_rd_kind ? csvt_pkg::CH_TAB : csvt_pkg::CH_SP);
            r_q     <= 1'b0;
            r_ecode <= 3'd0;
            r_eline <= 32'd0;
            r_ecol  <= 16'd0;
            r_last  <= i_cmd.emit_hold;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_token_kind    = r_kind;
    assign o_out_byte      = r_byte;
    assign o_was_quoted    = r_q;
    assign o_error_code    = r_ecode;
    assign o_line_number   = r_eline;
    assign o_column_number = r_ecol;
    assign o_last_of_run   = r_last;

endmodule

>>> src/csvt_chk.sv
// Port-level checker for the CSV stream tokenizer, bound to the top level.
module csvt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_in_byte,
    input logic        i_end_of_stream,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_token_kind,
    input logic [7:0]  o_out_byte,
    input logic        o_was_quoted,
    input logic [2:0]  o_error_code,
    input logic [31:0] o_line_number,
    input logic [15:0] o_column_number,
    input logic        o_last_of_run,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_index,
    input logic [7:0]  i_cfg_data
);

    // A stalled word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output word dropped while stalled");

    // An error is always the final word of its input.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind == csvt_pkg::TK_ERROR) |-> o_last_of_run)
        else $error("error word not marked last");

    // Nothing follows a delivered error.
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_token_kind == csvt_pkg::TK_ERROR)
        |=> !o_out_valid)
        else $error("word produced after latched error");

    // Error fields are zero on ordinary words.
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind != csvt_pkg::TK_ERROR)
        |-> (o_error_code == 3'd0 && o_line_number == 32'd0 && o_column_number == 16'd0))
        else $error("error fields set on a non-error word");

    // Content bytes never carry the quoted flag.
    a_byte_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind == csvt_pkg::TK_BYTE) |-> !o_was_quoted)
        else $error("quoted flag on a content byte");

endmodule

bind csv_stream_tokenizer_top csvt_chk u_csvt_chk (.*);
